// ----- rtl/hps_pkg.sv -----
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants for the host/port splitter
// Result layout, width of the result fields, the default length limit and the parser characters.
// ----------------------------------------------------------------------------
package hps_pkg;

    // Width of the length and offset fields of a result.
    localparam int unsigned FIELD_W = 11;

    // Default limit on the number of bytes in one string.
    localparam int unsigned DEF_MAX_LEN = 1024;

    // Characters the parser reacts to.
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_UNDER = 8'h5F;  // '_'

    // One result beat.
    typedef struct packed {
        logic               host_present;
        logic               host_offset;
        logic [FIELD_W-1:0] host_len;
        logic               port_present;
        logic [FIELD_W-1:0] port_offset;
        logic [FIELD_W-1:0] port_size;
        logic               too_long;
    } result_t;

endpackage

// ----- rtl/hps_scan.sv -----
// ----------------------------------------------------------------------------
// hps_scan: per-byte scanner of the host/port splitter
// Tracks the parse state of the current string and forms the result
// combinationally on the beat that closes the string.
// ----------------------------------------------------------------------------
module hps_scan #(
    parameter int unsigned MAX_LEN = hps_pkg::DEF_MAX_LEN
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       char_byte,
    input  logic             last,
    input  logic             empty_req,
    output logic             res_valid,
    output hps_pkg::result_t res
);

    localparam int unsigned PW = $clog2(MAX_LEN + 1);
    localparam int unsigned FW = hps_pkg::FIELD_W;
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_LEN);

    typedef enum logic [5:0] {
        PH_START = 6'b000001,
        PH_PLAIN = 6'b000010,
        PH_SEEK  = 6'b000100,
        PH_AFTER = 6'b001000,
        PH_PORT  = 6'b010000,
        PH_FAIL  = 6'b100000
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] colon_pos_reg, colon_pos_next;
    logic          colon_seen_reg, colon_seen_next;
    logic          tail_ok_reg, tail_ok_next;
    logic [PW-1:0] close_pos_reg, close_pos_next;
    logic          ovf_reg, ovf_next;

    logic          port_sym;
    logic          is_colon;
    logic [PW:0]   len_w;
    logic [PW:0]   colon_p1;
    logic [PW:0]   close_p2;
    logic          plain_port;
    logic          brk_ok;
    logic [PW:0]   host_len_w;
    logic [PW:0]   port_off_w;
    logic [PW:0]   port_size_w;
    hps_pkg::result_t res_c;

    function automatic logic [FW-1:0] to_field(input logic [PW:0] v);
        logic [PW+FW:0] ext;
        ext = {{FW{1'b0}}, v};
        return ext[FW-1:0];
    endfunction

    assign is_colon = (char_byte == hps_pkg::CH_COLON);
    assign port_sym = (char_byte == hps_pkg::CH_UNDER)
                   || (char_byte >= 8'h30 && char_byte <= 8'h39)
                   || (char_byte >= 8'h41 && char_byte <= 8'h5A)
                   || (char_byte >= 8'h61 && char_byte <= 8'h7A);

    // State update for one byte, before the end-of-string handling.
    always_comb begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        colon_pos_next  = colon_pos_reg;
        colon_seen_next = colon_seen_reg;
        tail_ok_next    = tail_ok_reg;
        close_pos_next  = close_pos_reg;
        ovf_next        = ovf_reg;
        if (pos_reg >= MAX_POS) begin
            ovf_next = 1'b1;
        end else begin
            pos_next = pos_reg + PW'(1);
            unique case (phase_reg)
                PH_START: begin
                    if (char_byte == hps_pkg::CH_OPEN) begin
                        phase_next = PH_SEEK;
                    end else begin
                        phase_next = PH_PLAIN;
                        if (is_colon) begin
                            colon_seen_next = 1'b1;
                            colon_pos_next  = pos_reg;
                            tail_ok_next    = 1'b1;
                        end
                    end
                end
                PH_PLAIN: begin
                    if (is_colon) begin
                        colon_seen_next = 1'b1;
                        colon_pos_next  = pos_reg;
                        tail_ok_next    = 1'b1;
                    end else if (colon_seen_reg && !port_sym) begin
                        tail_ok_next = 1'b0;
                    end
                end
                PH_SEEK: begin
                    if (char_byte == hps_pkg::CH_CLOSE) begin
                        close_pos_next = pos_reg;
                        phase_next     = PH_AFTER;
                    end
                end
                PH_AFTER: begin
                    if (is_colon) begin
                        phase_next   = PH_PORT;
                        tail_ok_next = 1'b1;
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_PORT: begin
                    if (!port_sym) begin
                        tail_ok_next = 1'b0;
                    end
                end
                PH_FAIL: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Result for a string that ends with this byte.
    assign len_w    = {1'b0, pos_next};
    assign colon_p1 = {1'b0, colon_pos_next} + (PW+1)'(1);
    assign close_p2 = {1'b0, close_pos_next} + (PW+1)'(2);

    assign plain_port = colon_seen_next && tail_ok_next && (len_w > colon_p1);
    assign brk_ok     = (phase_next == PH_AFTER)
                     || (tail_ok_next && (len_w > close_p2));

    always_comb begin
        res_c       = '0;
        host_len_w  = '0;
        port_off_w  = '0;
        port_size_w = '0;
        if (ovf_next) begin
            res_c.too_long = 1'b1;
        end else if (phase_next == PH_PLAIN) begin
            if (plain_port) begin
                res_c.host_present = (colon_pos_next != '0);
                host_len_w         = res_c.host_present ? {1'b0, colon_pos_next} : '0;
                res_c.port_present = 1'b1;
                port_off_w         = colon_p1;
                port_size_w        = len_w - colon_p1;
            end else begin
                res_c.host_present = 1'b1;
                host_len_w         = len_w;
            end
        end else if (phase_next == PH_AFTER || phase_next == PH_PORT) begin
            if (phase_next == PH_PORT && brk_ok) begin
                res_c.port_present = 1'b1;
                port_off_w         = close_p2;
                port_size_w        = len_w - close_p2;
            end
            if (brk_ok && close_pos_next > PW'(1)) begin
                res_c.host_present = 1'b1;
                res_c.host_offset  = 1'b1;
                host_len_w         = {1'b0, close_pos_next} - (PW+1)'(1);
            end
        end
        res_c.host_len    = to_field(host_len_w);
        res_c.port_offset = to_field(port_off_w);
        res_c.port_size   = to_field(port_size_w);
        // An empty string reports nothing at all.
        if (empty_req) begin
            res_c = '0;
        end
    end

    assign res_valid = accept && (last || empty_req);
    assign res       = res_c;

    always_ff @(posedge aclk) begin
        if (!aresetn || res_valid) begin
            phase_reg      <= PH_START;
            pos_reg        <= '0;
            colon_pos_reg  <= '0;
            colon_seen_reg <= 1'b0;
            tail_ok_reg    <= 1'b1;
            close_pos_reg  <= '0;
            ovf_reg        <= 1'b0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            colon_pos_reg  <= colon_pos_next;
            colon_seen_reg <= colon_seen_next;
            tail_ok_reg    <= tail_ok_next;
            close_pos_reg  <= close_pos_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

// ----- rtl/host_port_splitter_core.sv -----
// ----------------------------------------------------------------------------
// host_port_splitter_core: splits an address string into host and port
// Bytes stream in one per beat; the closing beat yields one result beat.
// ----------------------------------------------------------------------------
//
//  Channel  Ports         Direction  Beat carries
//  input    s_*           in         one string byte, last mark, empty mark
//  result   m_*           out        host/port offsets, lengths, too_long
//
//  One input beat is taken every cycle while s_ready is high; the result of
//  a closing beat is registered in the result register, or skid while held.
//  A two-entry output buffer (result register plus skid register) lets input
//  continue while a result waits; s_ready drops only when both are full.
//  Synchronous active-low reset returns the scanner to the start of a string.
//
module host_port_splitter_core #(
    parameter int unsigned MAX_LEN = hps_pkg::DEF_MAX_LEN
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_char_byte,
    input  logic                        s_last,
    input  logic                        s_empty_req,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_host_present,
    output logic                        m_host_offset,
    output logic [hps_pkg::FIELD_W-1:0] m_host_len,
    output logic                        m_port_present,
    output logic [hps_pkg::FIELD_W-1:0] m_port_offset,
    output logic [hps_pkg::FIELD_W-1:0] m_port_size,
    output logic                        m_too_long
);

    logic             accept;
    logic             res_valid;
    hps_pkg::result_t res;
    hps_pkg::result_t out_reg;
    hps_pkg::result_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    hps_scan #(
        .MAX_LEN (MAX_LEN)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .char_byte (s_char_byte),
        .last      (s_last),
        .empty_req (s_empty_req),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_valid;
                if (res_valid) begin
                    out_reg <= res;
                end
            end
        end else if (res_valid) begin
            // Result register is held by the consumer; park the new beat.
            skid_reg       <= res;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_host_present = out_reg.host_present;
    assign m_host_offset  = out_reg.host_offset;
    assign m_host_len     = out_reg.host_len;
    assign m_port_present = out_reg.port_present;
    assign m_port_offset  = out_reg.port_offset;
    assign m_port_size    = out_reg.port_size;
    assign m_too_long     = out_reg.too_long;

endmodule

// ----- rtl/hps_checker.sv -----
// ----------------------------------------------------------------------------
// hps_checker: port-level checks for the host/port splitter
// Watches the result channel for consistency of the reported fields.
// ----------------------------------------------------------------------------
module hps_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_host_present,
    input logic                        m_host_offset,
    input logic [hps_pkg::FIELD_W-1:0] m_host_len,
    input logic                        m_port_present,
    input logic [hps_pkg::FIELD_W-1:0] m_port_offset,
    input logic [hps_pkg::FIELD_W-1:0] m_port_size,
    input logic                        m_too_long
);

    // A stalled result beat keeps its host length, port offset, port size and too_long flag.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_host_len)
            && $stable(m_port_offset) && $stable(m_port_size)
            && $stable(m_too_long))
        else $error("result beat changed while stalled");

    // An over-long string reports neither field.
    a_too_long: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_too_long |-> !m_host_present && !m_port_present)
        else $error("fields reported with too_long");

    // Absent fields read as zero.
    a_host_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_host_present |-> m_host_offset == 1'b0 && m_host_len == '0)
        else $error("absent host has nonzero fields");

    a_port_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_port_present |-> m_port_offset == '0 && m_port_size == '0)
        else $error("absent port has nonzero fields");

    // In plain form the port starts just past the colon that ends the host.
    a_plain_port: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_host_present && !m_host_offset && m_port_present
            |-> m_port_offset == m_host_len + hps_pkg::FIELD_W'(1))
        else $error("port offset does not follow host");

endmodule

bind host_port_splitter_core hps_checker u_hps_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_host_present (m_host_present),
    .m_host_offset  (m_host_offset),
    .m_host_len     (m_host_len),
    .m_port_present (m_port_present),
    .m_port_offset  (m_port_offset),
    .m_port_size    (m_port_size),
    .m_too_long     (m_too_long)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for host_port_splitter_core
// Streams address strings one byte per beat and predicts the host and port
// fields of each result beat. Directed strings cover the bracket, colon,
// empty and over-long cases. Random strings follow, with both sides idling
// in bursts.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned TB_MAX_LEN = hps_pkg::DEF_MAX_LEN;
    localparam int unsigned FW         = hps_pkg::FIELD_W;

    typedef enum logic [5:0] {
        SCAN_START   = 6'b000001,
        SCAN_PLAIN   = 6'b000010,
        SCAN_BRACKET = 6'b000100,
        SCAN_CLOSED  = 6'b001000,
        SCAN_PORT    = 6'b010000,
        SCAN_REJECT  = 6'b100000
    } scan_phase_t;

    class split_scoreboard_t;
        int unsigned      limit_len;
        scan_phase_t      ph;
        int unsigned      pos;
        int unsigned      colon_at;
        int unsigned      close_at;
        bit               colon_seen;
        bit               tail_ok;
        bit               overflow;
        hps_pkg::result_t split_q[$];
        int               mismatches;
        int               checked;

        function new(int unsigned max_len);
            limit_len  = max_len;
            mismatches = 0;
            checked    = 0;
            restart();
        endfunction

        function void restart();
            ph         = SCAN_START;
            pos        = 0;
            colon_at   = 0;
            close_at   = 0;
            colon_seen = 1'b0;
            tail_ok    = 1'b1;
            overflow   = 1'b0;
        endfunction

        function bit is_service_char(logic [7:0] c);
            return (c == hps_pkg::CH_UNDER) || (c >= "0" && c <= "9") ||
                   (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function void take_byte(logic [7:0] c);
            int unsigned idx;
            idx = pos;
            // Bytes past the limit only mark the string as too long.
            if (pos >= limit_len) begin
                overflow = 1'b1;
                return;
            end
            pos++;
            case (ph) inside
                SCAN_START, SCAN_PLAIN: begin
                    if (ph == SCAN_START && c == hps_pkg::CH_OPEN) begin
                        ph = SCAN_BRACKET;
                    end else begin
                        ph = SCAN_PLAIN;
                        if (c == hps_pkg::CH_COLON) begin
                            colon_seen = 1'b1;
                            colon_at   = idx;
                            tail_ok    = 1'b1;
                        end else if (colon_seen && !is_service_char(c)) begin
                            tail_ok = 1'b0;
                        end
                    end
                end
                SCAN_BRACKET: begin
                    if (c == hps_pkg::CH_CLOSE) begin
                        close_at = idx;
                        ph       = SCAN_CLOSED;
                    end
                end
                SCAN_CLOSED: begin
                    if (c == hps_pkg::CH_COLON) begin
                        ph      = SCAN_PORT;
                        tail_ok = 1'b1;
                    end else begin
                        ph = SCAN_REJECT;
                    end
                end
                SCAN_PORT: begin
                    if (!is_service_char(c)) tail_ok = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void note_input(logic [7:0] c, logic is_last, logic is_empty);
            hps_pkg::result_t r;
            int unsigned      len;
            bit               ok;
            r = '0;
            if (is_empty) begin
                restart();
                split_q.push_back(r);
                return;
            end
            take_byte(c);
            if (!is_last) return;
            len = pos;
            if (overflow) begin
                r.too_long = 1'b1;
            end else if (ph == SCAN_PLAIN) begin
                if (colon_seen && tail_ok && len > colon_at + 1) begin
                    if (colon_at > 0) begin
                        r.host_present = 1'b1;
                        r.host_len     = FW'(colon_at);
                    end
                    r.port_present = 1'b1;
                    r.port_offset  = FW'(colon_at + 1);
                    r.port_size    = FW'(len - colon_at - 1);
                end else begin
                    r.host_present = 1'b1;
                    r.host_len     = FW'(len);
                end
            end else if (ph == SCAN_CLOSED || ph == SCAN_PORT) begin
                ok = 1'b1;
                if (ph == SCAN_PORT) begin
                    ok = tail_ok && len > close_at + 2;
                    if (ok) begin
                        r.port_present = 1'b1;
                        r.port_offset  = FW'(close_at + 2);
                        r.port_size    = FW'(len - close_at - 2);
                    end
                end
                // An empty bracket host counts as absent.
                if (ok && close_at > 1) begin
                    r.host_present = 1'b1;
                    r.host_offset  = 1'b1;
                    r.host_len     = FW'(close_at - 1);
                end
            end
            restart();
            split_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [FW-1:0] want, logic [FW-1:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: %s expected %0d, got %0d",
                             checked, name, want, got);
            end
        endfunction

        function void check_result(hps_pkg::result_t got);
            hps_pkg::result_t want;
            if (split_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with nothing expected: %h", got);
                return;
            end
            want = split_q.pop_front();
            compare_field("host_present", FW'(want.host_present), FW'(got.host_present));
            compare_field("host_offset",  FW'(want.host_offset),  FW'(got.host_offset));
            compare_field("host_len",     want.host_len,          got.host_len);
            compare_field("port_present", FW'(want.port_present), FW'(got.port_present));
            compare_field("port_offset",  want.port_offset,       got.port_offset);
            compare_field("port_size",    want.port_size,         got.port_size);
            compare_field("too_long",     FW'(want.too_long),     FW'(got.too_long));
            checked++;
        endfunction

        function int outstanding();
            return split_q.size();
        endfunction
    endclass

    logic          aclk;
    logic          aresetn     = 1'b0;
    logic          s_valid     = 1'b0;
    logic          s_ready;
    logic [7:0]    s_char_byte = 8'h00;
    logic          s_last      = 1'b0;
    logic          s_empty_req = 1'b0;
    logic          m_valid;
    logic          m_ready     = 1'b0;
    logic          m_host_present;
    logic          m_host_offset;
    logic [FW-1:0] m_host_len;
    logic          m_port_present;
    logic [FW-1:0] m_port_offset;
    logic [FW-1:0] m_port_size;
    logic          m_too_long;

    bit                idle_on     = 1'b1;
    int                beats_total = 0;
    split_scoreboard_t sb          = new(TB_MAX_LEN);

    host_port_splitter_core #(
        .MAX_LEN(TB_MAX_LEN)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_byte   (s_char_byte),
        .s_last        (s_last),
        .s_empty_req   (s_empty_req),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_host_present(m_host_present),
        .m_host_offset (m_host_offset),
        .m_host_len    (m_host_len),
        .m_port_present(m_port_present),
        .m_port_offset (m_port_offset),
        .m_port_size   (m_port_size),
        .m_too_long    (m_too_long)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Both handshakes are sampled here, inputs first, so a result can never
    // be checked ahead of the beat that caused it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_char_byte, s_last, s_empty_req);
            if (m_valid && m_ready)
                sb.check_result({m_host_present, m_host_offset, m_host_len,
                                 m_port_present, m_port_offset, m_port_size,
                                 m_too_long});
        end
    end

    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 16) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [7:0] c, input logic is_last,
                             input logic is_empty);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_byte <= c;
        s_last      <= is_last;
        s_empty_req <= is_empty;
        do @(posedge aclk); while (!s_ready);
        beats_total++;
    endtask

    task automatic send_bytes(input logic [7:0] text[$], input bit close);
        for (int i = 0; i < text.size(); i++)
            send_beat(text[i], close && (i == text.size() - 1), 1'b0);
    endtask

    task automatic send_text(input string s);
        logic [7:0] text[$];
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
        send_bytes(text, 1'b1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    function automatic logic [7:0] rand_port_char();
        case ($urandom_range(0, 3))
            0: return 8'("a" + $urandom_range(0, 25));
            1: return 8'("A" + $urandom_range(0, 25));
            2: return 8'("0" + $urandom_range(0, 9));
            default: return hps_pkg::CH_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] rand_host_char();
        case ($urandom_range(0, 19))
            0: return hps_pkg::CH_COLON;
            1: return ".";
            2: return "-";
            3: return 8'($urandom_range(0, 255));
            default: return rand_port_char();
        endcase
    endfunction

    function automatic logic [7:0] rand_special_char();
        case ($urandom_range(0, 7))
            0: return hps_pkg::CH_OPEN;
            1: return hps_pkg::CH_CLOSE;
            2: return hps_pkg::CH_COLON;
            3: return 8'($urandom_range(0, 255));
            default: return rand_port_char();
        endcase
    endfunction

    // A port byte that is occasionally not a valid port character.
    function automatic logic [7:0] rand_port_or_bad();
        if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
        return rand_port_char();
    endfunction

    function automatic void build_address(ref logic [7:0] text[$]);
        int form;
        int n;
        text.delete();
        form = $urandom_range(0, 99);
        if (form < 30) begin
            n = $urandom_range(0, 6);
            repeat (n) text.push_back(rand_host_char());
            text.push_back(hps_pkg::CH_COLON);
            n = $urandom_range(0, 5);
            repeat (n) text.push_back(rand_port_or_bad());
        end else if (form < 45) begin
            n = $urandom_range(1, 10);
            repeat (n) text.push_back(rand_host_char());
        end else if (form < 70) begin
            text.push_back(hps_pkg::CH_OPEN);
            n = $urandom_range(0, 6);
            repeat (n) text.push_back(rand_host_char());
            text.push_back(hps_pkg::CH_CLOSE);
            case ($urandom_range(0, 3))
                0: ;
                3: begin
                    n = $urandom_range(1, 3);
                    repeat (n) text.push_back(rand_special_char());
                end
                default: begin
                    text.push_back(hps_pkg::CH_COLON);
                    n = $urandom_range(0, 5);
                    repeat (n) text.push_back(rand_port_or_bad());
                end
            endcase
        end else if (form < 80) begin
            text.push_back(hps_pkg::CH_OPEN);
            n = $urandom_range(1, 6);
            repeat (n) text.push_back(rand_special_char());
        end else if (form < 95) begin
            n = $urandom_range(1, 10);
            repeat (n) text.push_back(rand_special_char());
        end else begin
            text.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    initial begin : stimulus
        logic [7:0] text[$];
        int         cut;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed strings.
        send_beat(8'hA5, 1'b1, 1'b1);
        send_text("a");
        send_text("h:8");
        send_text(":9");
        send_text("h:");
        send_text("::Z");
        send_text("a:b-");
        send_text("[]");
        send_text("[]:9");
        send_text("[a]:_");
        send_text("[a]");
        send_text("[a]:");
        send_text("[a]x");
        send_text("[a");
        send_text("[a]:~");
        // An empty request in the middle of a string drops what came before.
        send_beat("a", 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);

        // Hold off until the block has nothing left in flight.
        wait_drained();

        // One byte past the length limit.
        text.delete();
        repeat (TB_MAX_LEN + 1) text.push_back(8'($urandom_range(0, 255)));
        send_bytes(text, 1'b1);

        // Random strings.
        while (beats_total < 1950) begin
            if (beats_total > 1600) idle_on = 1'b0;
            else if ($urandom_range(0, 24) == 0) idle_on = !idle_on;

            if ($urandom_range(0, 29) == 0) begin
                send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end else begin
                build_address(text);
                if ($urandom_range(0, 19) == 0) begin
                    cut = $urandom_range(0, text.size() - 1);
                    text = text[0:cut];
                    send_bytes(text, 1'b0);
                    send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                end else begin
                    send_bytes(text, 1'b1);
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (sb.outstanding() != 0)
                $display("%0d expected results never arrived", sb.outstanding());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/hps_pkg.sv
rtl/hps_scan.sv
rtl/host_port_splitter_core.sv
rtl/hps_checker.sv
sim/testbench.sv
